@@ design/ptwu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptwu_pkg
// Shared types and constants for the page table walker with range unmap.
// ----------------------------------------------------------------------------
package ptwu_pkg;

  localparam int VA_BITS     = 48;
  localparam int IDX_BITS    = 9;
  localparam int OFFSET_BITS = 12;
  localparam int OQ_DEPTH    = 4;
  localparam int OQ_PTR_BITS = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_BITS = $clog2(OQ_DEPTH + 1);

  localparam logic [1:0] CMD_TRANSLATE = 2'd0;
  localparam logic [1:0] CMD_UNMAP     = 2'd1;
  localparam logic [1:0] CMD_REPLY     = 2'd2;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [63:0] OFFSET_MASK  = 64'h0000_0000_0000_0FFF;
  localparam logic [47:0] IDENT_RESET  = 48'h0000_0010_0000;
  localparam logic [48:0] VA_SPAN      = 49'h1_0000_0000_0000;
  localparam logic [48:0] PAGE_BYTES   = 49'd4096;

  localparam logic [3:0] ADDR_IDENT  = 4'h0;
  localparam logic [3:0] ADDR_WINDOW = 4'h8;

  typedef struct packed {
    logic [1:0]  command;
    logic [47:0] virt_addr;
    logic [47:0] range_bytes;
    logic [63:0] root_table;
    logic [63:0] read_data;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] mem_addr;
    logic [63:0] result_addr;
    logic        mapped;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic room;
  } oq_status_t;

  function automatic logic [IDX_BITS-1:0] level_index(logic [VA_BITS-1:0] va,
                                                      logic [1:0] lvl);
    logic [IDX_BITS-1:0] idx;
    case (lvl)
      2'd0: idx = va[47:39];
      2'd1: idx = va[38:30];
      2'd2: idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  function automatic logic [63:0] entry_addr(logic [63:0] base,
                                             logic [IDX_BITS-1:0] idx);
    return base + {52'd0, idx, 3'd0};
  endfunction

  function automatic rsp_t mk_rsp(logic [1:0] kind, logic [63:0] maddr,
                                  logic [63:0] raddr, logic mapped, logic last);
    rsp_t r;
    r.kind        = kind;
    r.mem_addr    = maddr;
    r.result_addr = raddr;
    r.mapped      = mapped;
    r.last        = last;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/ptwu_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptwu_core
// Walk state and the per-item decision: issues reads, zero writes and done.
// ----------------------------------------------------------------------------
module ptwu_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  ptwu_pkg::req_t      item,
  input  wire logic [47:0]    identity_limit,
  input  wire logic [63:0]    table_window,
  output logic [1:0]          res_count,
  output ptwu_pkg::rsp_t      res0,
  output ptwu_pkg::rsp_t      res1
);
  import ptwu_pkg::*;

  logic        busy, busy_next;
  logic        unmap_mode, unmap_mode_next;
  logic [1:0]  walk_level, walk_level_next;
  logic [47:0] current_virt, current_virt_next;
  logic [48:0] range_end, range_end_next;
  logic [63:0] saved_root, saved_root_next;
  logic        first_pending, first_pending_next;
  logic [63:0] first_phys, first_phys_next;
  logic [63:0] inflight_addr, inflight_addr_next;

  logic [48:0] end_raw, end_clip, next_va;
  logic [63:0] phys, fp_val;
  logic [1:0]  lvl_up;

  always_comb begin
    busy_next          = busy;
    unmap_mode_next    = unmap_mode;
    walk_level_next    = walk_level;
    current_virt_next  = current_virt;
    range_end_next     = range_end;
    saved_root_next    = saved_root;
    first_pending_next = first_pending;
    first_phys_next    = first_phys;
    inflight_addr_next = inflight_addr;
    res_count          = 2'd0;
    res0               = '0;
    res1               = '0;

    end_raw  = {1'b0, item.virt_addr} + {1'b0, item.range_bytes};
    end_clip = (end_raw > VA_SPAN) ? VA_SPAN : end_raw;
    next_va  = {1'b0, current_virt} + PAGE_BYTES;
    phys     = (item.read_data & ~OFFSET_MASK) | {52'd0, current_virt[11:0]};
    fp_val   = first_pending ? phys : first_phys;
    lvl_up   = walk_level + 2'd1;

    case (item.command)
      CMD_TRANSLATE, CMD_UNMAP: begin
        if (!busy) begin
          res_count = 2'd1;
          if (item.virt_addr < identity_limit) begin
            res0 = mk_rsp(KIND_DONE, '0, {16'd0, item.virt_addr}, 1'b0, 1'b1);
          end else if (item.command == CMD_UNMAP && {1'b0, item.virt_addr} >= end_clip) begin
            res0 = mk_rsp(KIND_DONE, '0, '0, 1'b0, 1'b1);
          end else begin
            if (item.command == CMD_UNMAP) begin
              range_end_next     = end_clip;
              first_pending_next = 1'b1;
              first_phys_next    = '0;
            end
            unmap_mode_next    = (item.command == CMD_UNMAP);
            saved_root_next    = item.root_table;
            current_virt_next  = item.virt_addr;
            busy_next          = 1'b1;
            walk_level_next    = 2'd0;
            inflight_addr_next = entry_addr(item.root_table,
                                            level_index(item.virt_addr, 2'd0));
            res0 = mk_rsp(KIND_READ, inflight_addr_next, '0, 1'b0, 1'b1);
          end
        end
      end
      CMD_REPLY: begin
        if (busy) begin
          if (walk_level != 2'd3) begin
            res_count = 2'd1;
            if (item.read_data == '0) begin
              busy_next = 1'b0;
              res0 = mk_rsp(KIND_DONE, '0, {16'd0, current_virt}, 1'b0, 1'b1);
            end else begin
              walk_level_next    = lvl_up;
              inflight_addr_next = entry_addr((item.read_data & ~OFFSET_MASK) | table_window,
                                              level_index(current_virt, lvl_up));
              res0 = mk_rsp(KIND_READ, inflight_addr_next, '0, 1'b0, 1'b1);
            end
          end else if (!unmap_mode) begin
            res_count = 2'd1;
            busy_next = 1'b0;
            res0 = mk_rsp(KIND_DONE, '0, phys, 1'b1, 1'b1);
          end else begin
            res_count          = 2'd2;
            first_phys_next    = fp_val;
            first_pending_next = 1'b0;
            walk_level_next    = 2'd0;
            res0 = mk_rsp(KIND_WRITE, inflight_addr, '0, 1'b0, 1'b0);
            if (next_va < range_end) begin
              current_virt_next  = next_va[47:0];
              inflight_addr_next = entry_addr(saved_root, level_index(next_va[47:0], 2'd0));
              res1 = mk_rsp(KIND_READ, inflight_addr_next, '0, 1'b0, 1'b1);
            end else begin
              busy_next = 1'b0;
              res1 = mk_rsp(KIND_DONE, '0, fp_val, 1'b1, 1'b1);
            end
          end
        end
      end
      default: ;
    endcase

    if (!fire) begin
      res_count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      unmap_mode    <= 1'b0;
      walk_level    <= 2'd0;
      current_virt  <= '0;
      range_end     <= '0;
      saved_root    <= '0;
      first_pending <= 1'b1;
      first_phys    <= '0;
      inflight_addr <= '0;
    end else if (fire) begin
      busy          <= busy_next;
      unmap_mode    <= unmap_mode_next;
      walk_level    <= walk_level_next;
      current_virt  <= current_virt_next;
      range_end     <= range_end_next;
      saved_root    <= saved_root_next;
      first_pending <= first_pending_next;
      first_phys    <= first_phys_next;
      inflight_addr <= inflight_addr_next;
    end
  end

endmodule
`default_nettype wire

@@ design/ptwu_outq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptwu_outq
// Result queue: takes up to two results a cycle, hands out one a cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module ptwu_outq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [1:0]        push_count,
  input  ptwu_pkg::rsp_t         push0,
  input  ptwu_pkg::rsp_t         push1,
  output ptwu_pkg::oq_status_t   status,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output ptwu_pkg::rsp_t         rsp
);
  import ptwu_pkg::*;

  rsp_t                   slots [OQ_DEPTH];
  logic [OQ_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [OQ_CNT_BITS-1:0] count;
  logic                   pop;
  logic [OQ_PTR_BITS-1:0] wr_ptr1;

  assign rsp_valid   = (count != '0);
  assign rsp         = slots[rd_ptr];
  assign pop         = rsp_valid && rsp_ready;
  assign wr_ptr1     = wr_ptr + OQ_PTR_BITS'(1);
  assign status.room = (count <= OQ_CNT_BITS'(OQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      slots[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      slots[wr_ptr1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_PTR_BITS'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_PTR_BITS'(1);
      end
      count <= count + OQ_CNT_BITS'(push_count) - OQ_CNT_BITS'(pop);
    end
  end

endmodule
`default_nettype wire

@@ design/page_table_walk_unmap.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// page_table_walk_unmap
// Four-level page table walker with range unmap behind a memory request port.
// ----------------------------------------------------------------------------
// Requests (translate, unmap range) and memory read replies arrive as items
// on the req channel; read requests, zero writes and done results leave on the
// rsp channel. An item is taken into an input register, decided by the walk
// logic once the result queue has room and written into a four-entry result
// queue. One item is accepted per cycle while the queue has room and each
// item yields a single result; an unmap leaf reply yields two results, so
// the rsp port (one result per cycle) sets the rate then.
// Throughput of a walk is set by the external memory reply latency.
// Registers: identity_limit at 0x0, table_window at 0x8 (64-bit APB data).
module page_table_walk_unmap (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  ptwu_pkg::req_t      req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output ptwu_pkg::rsp_t      rsp,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [3:0]     paddr,
  input  wire logic [63:0]    pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  import ptwu_pkg::*;

  logic        identity_limit_q;
  logic [47:0] identity_limit;
  logic [63:0] table_window;
  logic        cfg_wr;

  logic        hold_valid;
  req_t        hold;
  logic        fire;
  oq_status_t  oq_status;
  logic [1:0]  res_count;
  rsp_t        res0, res1;

  assign identity_limit_q = 1'b0;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[3] ? table_window : {16'd0, identity_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      identity_limit <= IDENT_RESET;
      table_window   <= '0;
    end else if (cfg_wr) begin
      if (paddr[3] == ADDR_WINDOW[3]) begin
        table_window <= pwdata;
      end else begin
        identity_limit <= pwdata[47:0] | {47'd0, identity_limit_q};
      end
    end
  end

  assign fire      = hold_valid && oq_status.room;
  assign req_ready = !hold_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_ready) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      hold <= req;
    end
  end

  ptwu_core u_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .item           (hold),
    .identity_limit (identity_limit),
    .table_window   (table_window),
    .res_count      (res_count),
    .res0           (res0),
    .res1           (res1)
  );

  ptwu_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_count (res_count),
    .push0      (res0),
    .push1      (res1),
    .status     (oq_status),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

endmodule
`default_nettype wire
